/* rtl/core/osa_pkg.sv */
// osa_pkg: shared constants, register codes, cursor type and dimension clamp
// for the burst slot allocator; no dependencies
package osa_pkg;

   // grid limits
   localparam int MAX_ROWS  = 64;
   localparam int MAX_COLS  = 64;
   localparam int PAIR_STEP = 2;

   // field widths
   localparam int ROW_W  = 6;
   localparam int COL_W  = 7;
   localparam int SIZE_W = 13;
   localparam int RANK_W = 12;
   localparam int FREE_W = 13;
   localparam int CFG_W  = 7;

   // register port
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;

   localparam logic [RANK_W-1:0]       RANK_MAX = {RANK_W{1'b1}};
   localparam logic [FREE_W-1:0]       FREE_MAX = {FREE_W{1'b1}};
   localparam logic signed [COL_W-1:0] PAIR_DEC = COL_W'(PAIR_STEP);
   localparam logic signed [COL_W-1:0] COL_NONE = {COL_W{1'b1}};

   typedef enum logic {
      REG_GRID_ROWS = 1'b0,
      REG_GRID_COLS = 1'b1
   } reg_idx_type;

   // placement cursor: slots still to place, row, right column of the pair
   typedef struct packed {
      logic [SIZE_W-1:0] need;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
   } cursor_type;

   // clamp a grid dimension to 1..vmax
   function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] vmax);
      logic [CFG_W-1:0] r;
      r = v;
      if (v == '0) r = CFG_W'(1);
      else if (v > vmax) r = vmax;
      return r;
   endfunction

endpackage

/* rtl/core/osa_step.sv */
// osa_step: one slot-pair placement step of the cursor
// depends on osa_pkg
module osa_step (
   input  osa_pkg::cursor_type       cur_i,
   input  logic [osa_pkg::ROW_W-1:0] rows_m1_i,
   output osa_pkg::cursor_type       nxt_o,
   output logic                      busy_o
);
   import osa_pkg::*;

   logic [SIZE_W-1:0]       need_m1;
   logic                    left_ok;
   logic signed [COL_W-1:0] col_s;
   logic signed [COL_W-1:0] col_m2;

   assign col_s = $signed(cur_i.col);

   // more slots to place and grid not exhausted
   assign busy_o = (cur_i.need != '0) && !cur_i.col[COL_W-1];

   // right slot always, left slot if wanted and on the grid
   assign need_m1 = cur_i.need - SIZE_W'(1);
   assign left_ok = (need_m1 != '0) && !cur_i.col[COL_W-1] && (cur_i.col != '0);

   // wrap to the bottom row two columns further left, stop at minus one
   assign col_m2 = col_s - PAIR_DEC;

   always_comb begin
      nxt_o.need = left_ok ? (need_m1 - SIZE_W'(1)) : need_m1;
      if (cur_i.row == '0) begin
         nxt_o.row = rows_m1_i;
         nxt_o.col = (col_m2 < COL_NONE) ? COL_NONE : col_m2;
      end else begin
         nxt_o.row = cur_i.row - ROW_W'(1);
         nxt_o.col = cur_i.col;
      end
   end

endmodule

/* rtl/core/osa_ctrl.sv */
// osa_ctrl: sequencer, allocator state and result register
// depends on osa_pkg and osa_step
module osa_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [osa_pkg::CFG_W-1:0]   rows_i,
   input  logic [osa_pkg::CFG_W-1:0]   cols_i,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [osa_pkg::SIZE_W-1:0]  req_burst_size,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_accepted,
   output logic [osa_pkg::RANK_W-1:0]  rsp_burst_rank,
   output logic [osa_pkg::ROW_W-1:0]   rsp_start_row,
   output logic signed [osa_pkg::COL_W-1:0] rsp_start_col,
   output logic [osa_pkg::ROW_W-1:0]   rsp_next_row,
   output logic signed [osa_pkg::COL_W-1:0] rsp_next_col,
   output logic [osa_pkg::FREE_W-1:0]  rsp_slots_left
);
   import osa_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RUN,
      ST_FINISH
   } state_type;

   state_type           state_ff;
   logic                started_ff;
   cursor_type          cur_ff;
   logic [FREE_W-1:0]   free_ff;
   logic [RANK_W-1:0]   rank_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic                acc_ff;
   logic [RANK_W-1:0]   rank_res_ff;
   logic [ROW_W-1:0]    srow_ff;
   logic [COL_W-1:0]    scol_ff;

   logic                rsp_valid_ff;
   logic                rsp_acc_ff;
   logic [RANK_W-1:0]   rsp_rank_ff;
   logic [ROW_W-1:0]    rsp_srow_ff;
   logic [COL_W-1:0]    rsp_scol_ff;
   logic [ROW_W-1:0]    rsp_nrow_ff;
   logic [COL_W-1:0]    rsp_ncol_ff;
   logic [FREE_W-1:0]   rsp_left_ff;

   logic [CFG_W-1:0]    rows_m1_full;
   logic [CFG_W-1:0]    cols_m1_full;
   logic [ROW_W-1:0]    rows_m1;
   logic [2*CFG_W-1:0]  area;
   logic [FREE_W-1:0]   free_init;
   logic [FREE_W:0]     dec;
   cursor_type          step_nxt;
   logic                step_busy;
   logic                rsp_load;

   // first-burst load values
   assign rows_m1_full = rows_i - CFG_W'(1);
   assign cols_m1_full = cols_i - CFG_W'(1);
   assign rows_m1      = rows_m1_full[ROW_W-1:0];
   assign area         = rows_i * cols_i;
   assign free_init    = (area > (2*CFG_W)'(FREE_MAX)) ? FREE_MAX : area[FREE_W-1:0];

   // free count charge: size rounded up to even
   assign dec = {1'b0, size_ff} + (FREE_W+1)'(size_ff[0]);

   // finished result moves into the output register once it is free
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   osa_step u_step (
      .cur_i     (cur_ff),
      .rows_m1_i (rows_m1),
      .nxt_o     (step_nxt),
      .busy_o    (step_busy)
   );

   // sequencer, allocator state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         cur_ff       <= '0;
         free_ff      <= '0;
         rank_ff      <= RANK_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         // output register valid: set on load, cleared on a response transfer
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  size_ff     <= req_burst_size;
                  cur_ff.need <= req_burst_size;
                  if (!started_ff) begin
                     cur_ff.row <= rows_m1;
                     cur_ff.col <= cols_m1_full;
                     free_ff    <= free_init;
                     started_ff <= 1'b1;
                  end
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               srow_ff <= cur_ff.row;
               scol_ff <= cur_ff.col;
               if (free_ff > size_ff) begin
                  state_ff <= ST_RUN;
               end else begin
                  acc_ff      <= 1'b0;
                  rank_res_ff <= '0;
                  state_ff    <= ST_FINISH;
               end
            end
            ST_RUN: begin
               if (step_busy) begin
                  cur_ff <= step_nxt;
               end else begin
                  free_ff     <= (dec >= {1'b0, free_ff}) ? '0 : free_ff - dec[FREE_W-1:0];
                  acc_ff      <= 1'b1;
                  rank_res_ff <= rank_ff;
                  if (rank_ff < RANK_MAX) rank_ff <= rank_ff + RANK_W'(1);
                  state_ff    <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               // load the result once the output register is free
               if (rsp_load) begin
                  rsp_acc_ff   <= acc_ff;
                  rsp_rank_ff  <= rank_res_ff;
                  rsp_srow_ff  <= srow_ff;
                  rsp_scol_ff  <= scol_ff;
                  rsp_nrow_ff  <= cur_ff.row;
                  rsp_ncol_ff  <= cur_ff.col;
                  rsp_left_ff  <= free_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = rsp_acc_ff;
   assign rsp_burst_rank = rsp_rank_ff;
   assign rsp_start_row  = rsp_srow_ff;
   assign rsp_start_col  = $signed(rsp_scol_ff);
   assign rsp_next_row   = rsp_nrow_ff;
   assign rsp_next_col   = $signed(rsp_ncol_ff);
   assign rsp_slots_left = rsp_left_ff;

   // column cursor never drops below minus one
   a_col_floor: assert property (@(posedge clock) disable iff (reset)
      !($signed(cur_ff.col) < COL_NONE))
      else $error("column cursor below minus one");

   // rank counter never wraps to zero
   a_rank_nonzero: assert property (@(posedge clock) disable iff (reset)
      rank_ff != '0)
      else $error("rank counter reached zero");

   // a placed burst always carries a nonzero rank
   a_acc_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_acc_ff |-> rsp_rank_ff != '0)
      else $error("placed burst without rank");

   // a rejected burst leaves the cursor where it was
   a_reject_still: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_acc_ff |->
         (rsp_nrow_ff == rsp_srow_ff) && (rsp_ncol_ff == rsp_scol_ff))
      else $error("rejected burst moved the cursor");

   // the first transfer loads the grid and marks the allocator started
   a_started: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !started_ff |=> started_ff)
      else $error("first burst did not load the grid");

endmodule

/* rtl/core/ofdma_burst_slot_allocator_top.sv */
// ofdma_burst_slot_allocator_top: register port, dimension clamp and allocator core
// depends on osa_pkg, osa_ctrl and osa_step
//
// Places bursts into a rows-by-columns slot grid, one burst per request transfer.
// Request channel (req_valid/req_ready, req_burst_size) carries the slot count;
// the response channel (rsp_valid/rsp_ready) returns one result per request:
// accepted flag, rank, start and next cursor, and the remaining free count.
// grid_rows lies at byte address 0 and grid_cols at 4 on the APB-style port;
// both reset to 64 and should be written only while the allocator is idle.
// The first burst after reset loads the cursor to the bottom-right pair and the
// free count to rows times columns.
// A rejected burst goes from the check state straight to the finish state; a
// placed burst first passes through the run state, where the single placement
// step unit advances the cursor by one pair per cycle. In the finish state the
// result moves into the output register once it is free. req_ready is high
// only while the sequencer is idle, so one burst is in work at a time.
// A stalled response sits in the output register and the next request may be
// taken meanwhile; its result waits until that one is taken.
// Reset is synchronous and active high; it clears the sequencer, the cursor,
// the free count, the rank (back to 1) and the response valid.
module ofdma_burst_slot_allocator_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [osa_pkg::ADDR_W-1:0]       paddr,
   input  logic [osa_pkg::DATA_W-1:0]       pwdata,
   output logic [osa_pkg::DATA_W-1:0]       prdata,
   output logic                             pready,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [osa_pkg::SIZE_W-1:0]       req_burst_size,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_accepted,
   output logic [osa_pkg::RANK_W-1:0]       rsp_burst_rank,
   output logic [osa_pkg::ROW_W-1:0]        rsp_start_row,
   output logic signed [osa_pkg::COL_W-1:0] rsp_start_col,
   output logic [osa_pkg::ROW_W-1:0]        rsp_next_row,
   output logic signed [osa_pkg::COL_W-1:0] rsp_next_col,
   output logic [osa_pkg::FREE_W-1:0]       rsp_slots_left
);
   import osa_pkg::*;

   logic [CFG_W-1:0] rows_ff;
   logic [CFG_W-1:0] cols_ff;
   logic [CFG_W-1:0] rows_eff;
   logic [CFG_W-1:0] cols_eff;
   logic             wr_en;
   reg_idx_type      reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_sel = reg_idx_type'(paddr[2]);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= CFG_W'(MAX_ROWS);
         cols_ff <= CFG_W'(MAX_COLS);
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_GRID_ROWS: rows_ff <= pwdata[CFG_W-1:0];
            REG_GRID_COLS: cols_ff <= pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (reg_sel)
         REG_GRID_ROWS: prdata = {{(DATA_W-CFG_W){1'b0}}, rows_ff};
         REG_GRID_COLS: prdata = {{(DATA_W-CFG_W){1'b0}}, cols_ff};
         default:       prdata = '0;
      endcase
   end

   // effective grid dimensions
   assign rows_eff = clamp_dim(rows_ff, CFG_W'(MAX_ROWS));
   assign cols_eff = clamp_dim(cols_ff, CFG_W'(MAX_COLS));

   osa_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .rows_i         (rows_eff),
      .cols_i         (cols_eff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_burst_size (req_burst_size),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_accepted   (rsp_accepted),
      .rsp_burst_rank (rsp_burst_rank),
      .rsp_start_row  (rsp_start_row),
      .rsp_start_col  (rsp_start_col),
      .rsp_next_row   (rsp_next_row),
      .rsp_next_col   (rsp_next_col),
      .rsp_slots_left (rsp_slots_left)
   );

endmodule

/* sim/tb.sv */
// tb: self-checking testbench for ofdma_burst_slot_allocator_top, with its own
// placement predictor, randomised sender gaps and response stalls
// depends on osa_pkg and the allocator rtl
module tb;
   import osa_pkg::*;

   localparam int SIZE_ALL = (1 << SIZE_W) - 1;

   // one response transfer as seen on the rsp_ ports
   typedef struct packed {
      logic                     accepted;
      logic [RANK_W-1:0]        rank;
      logic [ROW_W-1:0]         start_row;
      logic signed [COL_W-1:0]  start_col;
      logic [ROW_W-1:0]         next_row;
      logic signed [COL_W-1:0]  next_col;
      logic [FREE_W-1:0]        slots_left;
   } placement_type;

   typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_CYCLIC} ready_mode_type;

   // tracks the frame cursor, free count and rank, and the placements still owed
   class placement_scoreboard;
      logic [CFG_W-1:0] rows_reg;
      logic [CFG_W-1:0] cols_reg;
      bit               started;
      int               row_cur;
      int               col_cur;
      int               free_slots;
      int               rank_next;
      int               errors;
      placement_type    placements_owed[$];

      function new();
         rows_reg   = CFG_W'(MAX_ROWS);
         cols_reg   = CFG_W'(MAX_COLS);
         started    = 1'b0;
         row_cur    = 0;
         col_cur    = 0;
         free_slots = 0;
         rank_next  = 1;
         errors     = 0;
      endfunction

      function void write_reg(reg_idx_type idx, logic [CFG_W-1:0] val);
         if (idx == REG_GRID_ROWS) rows_reg = val;
         else cols_reg = val;
      endfunction

      function int grid_dim(int v, int vmax);
         if (v < 1) return 1;
         if (v > vmax) return vmax;
         return v;
      endfunction

      // predicted placement of one burst taken on the request channel
      function void note_burst(logic [SIZE_W-1:0] size);
         placement_type p;
         int rows;
         int cols;
         int need;
         int dec;
         rows = grid_dim(rows_reg, MAX_ROWS);
         cols = grid_dim(cols_reg, MAX_COLS);
         // first burst of the frame loads cursor and free count, placed or not
         if (!started) begin
            free_slots = (rows * cols > int'(FREE_MAX)) ? int'(FREE_MAX) : rows * cols;
            row_cur    = rows - 1;
            col_cur    = cols - 1;
            started    = 1'b1;
         end
         p.start_row = row_cur[ROW_W-1:0];
         p.start_col = col_cur[COL_W-1:0];
         p.accepted  = (free_slots > int'(size));
         p.rank      = '0;
         if (p.accepted) begin
            need = size;
            dec  = size + (size & 1);
            // one pair per step, right slot then left, moving up the rows
            while (need > 0 && col_cur >= 0) begin
               need--;
               if (need > 0 && col_cur - 1 >= 0) need--;
               row_cur--;
               if (row_cur < 0) begin
                  row_cur = rows - 1;
                  col_cur -= PAIR_STEP;
                  if (col_cur < -1) col_cur = -1;
               end
            end
            free_slots = (dec >= free_slots) ? 0 : free_slots - dec;
            p.rank     = rank_next[RANK_W-1:0];
            if (rank_next < int'(RANK_MAX)) rank_next++;
         end
         p.next_row   = row_cur[ROW_W-1:0];
         p.next_col   = col_cur[COL_W-1:0];
         p.slots_left = free_slots[FREE_W-1:0];
         placements_owed.push_back(p);
      endfunction

      function void field_check(string name, int want, int got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_result(placement_type got);
         placement_type want;
         if (placements_owed.size() == 0) begin
            errors++;
            $display("%0t: response transfer with no burst outstanding", $time);
            return;
         end
         want = placements_owed.pop_front();
         field_check("accepted", want.accepted, got.accepted);
         field_check("burst_rank", want.rank, got.rank);
         field_check("start_row", want.start_row, got.start_row);
         field_check("start_col", want.start_col, got.start_col);
         field_check("next_row", want.next_row, got.next_row);
         field_check("next_col", want.next_col, got.next_col);
         field_check("slots_left", want.slots_left, got.slots_left);
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [ADDR_W-1:0]        paddr = '0;
   logic [DATA_W-1:0]        pwdata = '0;
   logic [DATA_W-1:0]        prdata;
   logic                     pready;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [SIZE_W-1:0]        req_burst_size = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_accepted;
   logic [RANK_W-1:0]        rsp_burst_rank;
   logic [ROW_W-1:0]         rsp_start_row;
   logic signed [COL_W-1:0]  rsp_start_col;
   logic [ROW_W-1:0]         rsp_next_row;
   logic signed [COL_W-1:0]  rsp_next_col;
   logic [FREE_W-1:0]        rsp_slots_left;

   ready_mode_type           ready_mode = RDY_ALWAYS;
   int                       ready_cnt = 0;
   placement_scoreboard      sb;

   ofdma_burst_slot_allocator_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_burst_size (req_burst_size),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_accepted   (rsp_accepted),
      .rsp_burst_rank (rsp_burst_rank),
      .rsp_start_row  (rsp_start_row),
      .rsp_start_col  (rsp_start_col),
      .rsp_next_row   (rsp_next_row),
      .rsp_next_col   (rsp_next_col),
      .rsp_slots_left (rsp_slots_left)
   );

   always #5 clock = ~clock;

   // compare every response transfer with the oldest owed placement
   always @(posedge clock) begin
      placement_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.accepted   = rsp_accepted;
         got.rank       = rsp_burst_rank;
         got.start_row  = rsp_start_row;
         got.start_col  = rsp_start_col;
         got.next_row   = rsp_next_row;
         got.next_col   = rsp_next_col;
         got.slots_left = rsp_slots_left;
         sb.check_result(got);
      end
   end

   // receiver stalls: a randomly chosen ready pattern, redrawn whenever its hold counter runs out
   always @(negedge clock) begin
      if (ready_cnt == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
         ready_cnt  <= $urandom_range(16, 96);
      end else begin
         ready_cnt <= ready_cnt - 1;
      end
      case (ready_mode)
         RDY_ALWAYS: rsp_ready <= 1'b1;
         RDY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         RDY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:    rsp_ready <= ((ready_cnt % 8) < 5);
      endcase
   end

   // one request transfer; valid stays high for whatever follows
   task automatic send_burst(input logic [SIZE_W-1:0] size);
      @(negedge clock);
      req_valid      <= 1'b1;
      req_burst_size <= size;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_burst(size);
   endtask

   // sender gap of the given number of cycles
   task automatic hold_off(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic drain();
      while (sb.placements_owed.size() != 0) @(posedge clock);
   endtask

   // register write: setup cycle then access cycle
   task automatic write_reg(input reg_idx_type idx, input logic [CFG_W-1:0] val);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(4 * idx);
      pwdata  <= DATA_W'(val);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // new grid setting once the allocator has gone idle
   task automatic reconfigure(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
      hold_off(1);
      drain();
      repeat (3) @(posedge clock);
      write_reg(REG_GRID_ROWS, rows);
      write_reg(REG_GRID_COLS, cols);
   endtask

   // mostly small bursts, some of 16 to 48 slots, some oversized ones and some sized at the free count
   function automatic logic [SIZE_W-1:0] pick_size(input int small_max);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 6) return SIZE_W'($urandom_range(SIZE_ALL, sb.free_slots));
      if (sel < 9) return SIZE_W'(sb.free_slots);
      if (sel < 17) return SIZE_W'($urandom_range(16, 48));
      return SIZE_W'($urandom_range(0, small_max));
   endfunction

   // bursty sender with random gaps and the odd wait for an idle allocator
   task automatic random_traffic(input int count, input int small_max);
      int sent;
      int run_len;
      bit no_gaps;
      sent = 0;
      while (sent < count) begin
         run_len = $urandom_range(1, 8);
         no_gaps = ($urandom_range(0, 3) == 0);
         repeat (run_len) begin
            send_burst(pick_size(small_max));
            sent++;
         end
         if (!no_gaps) begin
            hold_off($urandom_range(1, 12));
            if ($urandom_range(0, 11) == 0) drain();
         end
      end
   endtask

   localparam logic [SIZE_W-1:0] OPENING [13] = '{
      13'd4096, 13'd0, 13'd1, 13'd2, 13'd3, 13'd127, 13'd128,
      13'd2730, 13'd5461, 13'd5, 13'd1, 13'd0, 13'd63
   };

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // odd column count so the last pair column takes single slots
      write_reg(REG_GRID_ROWS, 7'd127);
      write_reg(REG_GRID_COLS, 7'd63);

      // first burst loads the frame even though it is refused
      send_burst(SIZE_W'(SIZE_ALL));
      // size equal to the free count is refused
      send_burst(SIZE_W'(sb.free_slots));
      foreach (OPENING[i]) send_burst(OPENING[i]);

      random_traffic(170, 13);

      // rows lowered below the cursor row
      reconfigure(7'd5, 7'd0);
      random_traffic(25, 7);

      // back-to-back zero-size bursts, each advancing the rank
      reconfigure(7'd127, 7'd127);
      repeat (10) send_burst('0);
      random_traffic(170, 13);

      // single row: every pair wraps, running the grid out of columns
      reconfigure(7'd0, 7'd2);
      random_traffic(60, 13);

      // a burst at the free count (refused) and one just under it, then bursts against what is left
      send_burst(SIZE_W'(sb.free_slots));
      send_burst(SIZE_W'(sb.free_slots == 0 ? 0 : sb.free_slots - 1));
      send_burst('0);
      send_burst(13'd1);
      send_burst(SIZE_W'(SIZE_ALL));

      hold_off(1);
      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.placements_owed.size() == 0) begin
         $display("ofdma_burst_slot_allocator_top test passed");
      end else begin
         $display("ofdma_burst_slot_allocator_top test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10000000;
      $display("ofdma_burst_slot_allocator_top test failed");
      $finish;
   end

endmodule
